[design/sparse_triplet_merge_add_core_assert.svh]
// Assertion macros shared by the sparse triplet merge modules.
`ifndef SPARSE_TRIPLET_MERGE_ADD_CORE_ASSERT_SVH
`define SPARSE_TRIPLET_MERGE_ADD_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define STMA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define STMA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define STMA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define STMA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

[design/stma_pkg.sv]
// Types and constants of the sparse triplet merge block.
package stma_pkg;

	localparam int ROW_W       = 10;
	localparam int COL_W       = 10;
	localparam int CFG_W       = 11;
	localparam int CMD_W       = 2;
	localparam int STAT_W      = 2;
	localparam int PADDR_W     = 4;
	localparam int PDATA_W     = 32;
	localparam int QUEUE_DEPTH = 2;

	// input commands
	localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_MERGE  = 2'd2;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_ROWS_A = 2'd0;
	localparam logic [1:0] REG_COLS_A = 2'd1;
	localparam logic [1:0] REG_ROWS_B = 2'd2;
	localparam logic [1:0] REG_COLS_B = 2'd3;

	// result status
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_DIM   = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_OVF   = 2'd3;

	typedef enum logic [1:0] {
		OP_LOAD_A = 2'd0,
		OP_LOAD_B = 2'd1,
		OP_MERGE  = 2'd2
	} op_t;

	// control part of a queued word
	typedef struct packed {
		op_t  op;
		logic dim_bad;
	} ctl_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_WALK = 1'b1
	} bk_state_t;

endpackage

[design/stma_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module stma_ram #(
	parameter int WIDTH = 52,
	parameter int DEPTH = 32
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[design/stma_front.sv]
// Front end: config registers, command accept and classification.
module stma_front #(
	parameter int MAX_DIM    = 1024,
	parameter int VALUE_BITS = 32,
	parameter int QW         = 55
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [stma_pkg::CMD_W-1:0]         command,
	input  logic [stma_pkg::ROW_W-1:0]         row,
	input  logic [stma_pkg::COL_W-1:0]         col,
	input  logic signed [VALUE_BITS-1:0]       value,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [stma_pkg::PADDR_W-1:0]       paddr,
	input  logic [stma_pkg::PDATA_W-1:0]       pwdata,
	output logic [stma_pkg::PDATA_W-1:0]       prdata,
	output logic                               pready,
	input  logic                               q_full,
	output logic                               q_push,
	output logic [QW-1:0]                      q_word
);
	localparam int PAD_W = stma_pkg::PDATA_W - stma_pkg::CFG_W;

	logic [stma_pkg::CFG_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic                       accept;
	logic                       dim_bad;
	stma_pkg::ctl_t             ctl;

	function automatic logic dim_out(input logic [stma_pkg::CFG_W-1:0] d);
		return (d == '0) || (32'(d) > 32'(MAX_DIM));
	endfunction

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q <= stma_pkg::CFG_W'(1);
			cols_a_q <= stma_pkg::CFG_W'(1);
			rows_b_q <= stma_pkg::CFG_W'(1);
			cols_b_q <= stma_pkg::CFG_W'(1);
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				stma_pkg::REG_ROWS_A: rows_a_q <= pwdata[stma_pkg::CFG_W-1:0];
				stma_pkg::REG_COLS_A: cols_a_q <= pwdata[stma_pkg::CFG_W-1:0];
				stma_pkg::REG_ROWS_B: rows_b_q <= pwdata[stma_pkg::CFG_W-1:0];
				stma_pkg::REG_COLS_B: cols_b_q <= pwdata[stma_pkg::CFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			stma_pkg::REG_ROWS_A: prdata = {{PAD_W{1'b0}}, rows_a_q};
			stma_pkg::REG_COLS_A: prdata = {{PAD_W{1'b0}}, cols_a_q};
			stma_pkg::REG_ROWS_B: prdata = {{PAD_W{1'b0}}, rows_b_q};
			stma_pkg::REG_COLS_B: prdata = {{PAD_W{1'b0}}, cols_b_q};
		endcase
	end

	// dimension check, taken with the merge word (user keeps config stable while busy; unenforced)
	assign dim_bad = (rows_a_q != rows_b_q) || (cols_a_q != cols_b_q) ||
		dim_out(rows_a_q) || dim_out(cols_a_q) ||
		dim_out(rows_b_q) || dim_out(cols_b_q);

	assign busy   = q_full;
	assign accept = start && !busy;

	always_comb begin
		ctl.op      = stma_pkg::OP_MERGE;
		ctl.dim_bad = dim_bad;
		q_push      = 1'b0;
		unique case (command)
			stma_pkg::CMD_LOAD_A: begin
				ctl.op = stma_pkg::OP_LOAD_A;
				q_push = accept;
			end
			stma_pkg::CMD_LOAD_B: begin
				ctl.op = stma_pkg::OP_LOAD_B;
				q_push = accept;
			end
			stma_pkg::CMD_MERGE: begin
				ctl.op = stma_pkg::OP_MERGE;
				q_push = accept;
			end
			default: q_push = 1'b0; // unused code: dropped
		endcase
	end

	assign q_word = {ctl, row, col, value};

endmodule

[design/stma_queue.sv]
// Short command queue between front and back end.
module stma_queue #(
	parameter int WIDTH = 55,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_word,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_word,
	output logic             empty
);
	`include "sparse_triplet_merge_add_core_assert.svh"

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_word = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= bump(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= bump(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	`STMA_ASSERT_IMP(a_q_no_overrun, clk, arst_n, push, !full, "push into full queue")
	`STMA_ASSERT_IMP(a_q_no_underrun, clk, arst_n, pop, !empty, "pop from empty queue")
	`STMA_ASSERT_IMP(a_q_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "count beyond depth")

endmodule

[design/stma_back.sv]
// Back end: list stores, load execution and merge walk.
module stma_back #(
	parameter int MAX_TERMS  = 32,
	parameter int VALUE_BITS = 32,
	parameter int QW         = 55
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_empty,
	input  logic [QW-1:0]                     q_word,
	output logic                              q_pop,
	output logic                              strobe,
	output logic [stma_pkg::ROW_W-1:0]        row_res,
	output logic [stma_pkg::COL_W-1:0]        col_res,
	output logic signed [VALUE_BITS:0]        sum_value,
	output logic                              entry_valid,
	output logic [stma_pkg::STAT_W-1:0]       status,
	output logic                              last
);
	`include "sparse_triplet_merge_add_core_assert.svh"

	localparam int AW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int VB    = VALUE_BITS;
	localparam int SW    = VALUE_BITS + 1;
	localparam int EW    = stma_pkg::ROW_W + stma_pkg::COL_W + VALUE_BITS;
	localparam int CTL_W = $bits(stma_pkg::ctl_t);

	stma_pkg::bk_state_t state_q, state_d;

	logic [CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
	logic [CNT_W-1:0] na_q, na_d, nb_q, nb_d;
	logic [CNT_W-1:0] i_q, i_d, j_q, j_d;
	logic             ovf_q, ovf_d;

	stma_pkg::ctl_t             ctl;
	logic [stma_pkg::ROW_W-1:0] ld_row;
	logic [stma_pkg::COL_W-1:0] ld_col;
	logic [VB-1:0]              ld_val;
	logic                       we_a, we_b;
	logic [EW-1:0]              rd_a, rd_b;

	logic [stma_pkg::ROW_W-1:0] a_row, b_row;
	logic [stma_pkg::COL_W-1:0] a_col, b_col;
	logic signed [SW-1:0]       a_ext, b_ext;
	logic                       a_has, b_has, a_first, b_first;

	logic                        emit;
	logic [stma_pkg::ROW_W-1:0]  e_row;
	logic [stma_pkg::COL_W-1:0]  e_col;
	logic signed [SW-1:0]        e_sum;
	logic                        e_valid, e_last;
	logic [stma_pkg::STAT_W-1:0] e_status;

	logic                        strobe_q, entry_valid_q, last_q;
	logic [stma_pkg::ROW_W-1:0]  row_q;
	logic [stma_pkg::COL_W-1:0]  col_q;
	logic signed [SW-1:0]        sum_q;
	logic [stma_pkg::STAT_W-1:0] status_q;

	assign ctl    = q_word[QW-1 -: CTL_W];
	assign ld_row = q_word[EW-1 -: stma_pkg::ROW_W];
	assign ld_col = q_word[EW-stma_pkg::ROW_W-1 -: stma_pkg::COL_W];
	assign ld_val = q_word[VB-1:0];

	// read address follows the next walk index, so data matches i_q / j_q
	stma_ram #(.WIDTH(EW), .DEPTH(MAX_TERMS)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (cnt_a_q[AW-1:0]),
		.wdata ({ld_row, ld_col, ld_val}),
		.raddr (i_d[AW-1:0]),
		.rdata (rd_a)
	);

	stma_ram #(.WIDTH(EW), .DEPTH(MAX_TERMS)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (cnt_b_q[AW-1:0]),
		.wdata ({ld_row, ld_col, ld_val}),
		.raddr (j_d[AW-1:0]),
		.rdata (rd_b)
	);

	assign a_row = rd_a[EW-1 -: stma_pkg::ROW_W];
	assign a_col = rd_a[EW-stma_pkg::ROW_W-1 -: stma_pkg::COL_W];
	assign a_ext = {rd_a[VB-1], rd_a[VB-1:0]};
	assign b_row = rd_b[EW-1 -: stma_pkg::ROW_W];
	assign b_col = rd_b[EW-stma_pkg::ROW_W-1 -: stma_pkg::COL_W];
	assign b_ext = {rd_b[VB-1], rd_b[VB-1:0]};

	assign a_has   = (i_q < na_q);
	assign b_has   = (j_q < nb_q);
	assign a_first = (a_row < b_row) || ((a_row == b_row) && (a_col < b_col));
	assign b_first = (a_row > b_row) || (a_col > b_col);

	always_comb begin
		state_d  = state_q;
		cnt_a_d  = cnt_a_q;
		cnt_b_d  = cnt_b_q;
		na_d     = na_q;
		nb_d     = nb_q;
		i_d      = i_q;
		j_d      = j_q;
		ovf_d    = ovf_q;
		q_pop    = 1'b0;
		we_a     = 1'b0;
		we_b     = 1'b0;
		emit     = 1'b0;
		e_row    = '0;
		e_col    = '0;
		e_sum    = '0;
		e_valid  = 1'b0;
		e_status = stma_pkg::ST_OK;
		e_last   = 1'b0;
		unique case (state_q)
			stma_pkg::BK_IDLE: begin
				i_d = '0;
				j_d = '0;
				if (!q_empty) begin
					q_pop = 1'b1;
					unique case (ctl.op)
						stma_pkg::OP_LOAD_A: begin
							if (cnt_a_q == CNT_W'(MAX_TERMS)) begin
								ovf_d = 1'b1;
							end else begin
								we_a    = 1'b1;
								cnt_a_d = cnt_a_q + CNT_W'(1);
							end
						end
						stma_pkg::OP_LOAD_B: begin
							if (cnt_b_q == CNT_W'(MAX_TERMS)) begin
								ovf_d = 1'b1;
							end else begin
								we_b    = 1'b1;
								cnt_b_d = cnt_b_q + CNT_W'(1);
							end
						end
						stma_pkg::OP_MERGE: begin
							na_d    = cnt_a_q;
							nb_d    = cnt_b_q;
							cnt_a_d = '0;
							cnt_b_d = '0;
							ovf_d   = 1'b0;
							priority if (ctl.dim_bad) begin
								emit     = 1'b1;
								e_status = stma_pkg::ST_DIM;
								e_last   = 1'b1;
							end else if (ovf_q) begin
								emit     = 1'b1;
								e_status = stma_pkg::ST_OVF;
								e_last   = 1'b1;
							end else if ((cnt_a_q == '0) && (cnt_b_q == '0)) begin
								emit     = 1'b1;
								e_status = stma_pkg::ST_EMPTY;
								e_last   = 1'b1;
							end else begin
								state_d = stma_pkg::BK_WALK;
							end
						end
						default: q_pop = 1'b1;
					endcase
				end
			end
			stma_pkg::BK_WALK: begin
				emit    = 1'b1;
				e_valid = 1'b1;
				priority if (a_has && b_has && a_first) begin
					e_row = a_row;
					e_col = a_col;
					e_sum = a_ext;
					i_d   = i_q + CNT_W'(1);
				end else if (a_has && b_has && b_first) begin
					e_row = b_row;
					e_col = b_col;
					e_sum = b_ext;
					j_d   = j_q + CNT_W'(1);
				end else if (a_has && b_has) begin
					// same coordinate: one entry with the sum, kept even if zero
					e_row = a_row;
					e_col = a_col;
					e_sum = a_ext + b_ext;
					i_d   = i_q + CNT_W'(1);
					j_d   = j_q + CNT_W'(1);
				end else if (a_has) begin
					e_row = a_row;
					e_col = a_col;
					e_sum = a_ext;
					i_d   = i_q + CNT_W'(1);
				end else begin
					e_row = b_row;
					e_col = b_col;
					e_sum = b_ext;
					j_d   = j_q + CNT_W'(1);
				end
				e_last = (i_d == na_q) && (j_d == nb_q);
				if (e_last) begin
					state_d = stma_pkg::BK_IDLE;
				end
			end
			default: state_d = stma_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= stma_pkg::BK_IDLE;
			cnt_a_q  <= '0;
			cnt_b_q  <= '0;
			na_q     <= '0;
			nb_q     <= '0;
			i_q      <= '0;
			j_q      <= '0;
			ovf_q    <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_a_q  <= cnt_a_d;
			cnt_b_q  <= cnt_b_d;
			na_q     <= na_d;
			nb_q     <= nb_d;
			i_q      <= i_d;
			j_q      <= j_d;
			ovf_q    <= ovf_d;
			strobe_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			row_q         <= e_row;
			col_q         <= e_col;
			sum_q         <= e_sum;
			entry_valid_q <= e_valid;
			status_q      <= e_status;
			last_q        <= e_last;
		end
	end

	assign strobe      = strobe_q;
	assign row_res     = row_q;
	assign col_res     = col_q;
	assign sum_value   = sum_q;
	assign entry_valid = entry_valid_q;
	assign status      = status_q;
	assign last        = last_q;

	`STMA_ASSERT_IMP(a_bk_walk_has_work, clk, arst_n, state_q == stma_pkg::BK_WALK, a_has || b_has, "walk with both lists drained")
	`STMA_ASSERT_IMP(a_bk_status_last, clk, arst_n, strobe_q && !entry_valid_q, last_q, "status word not marked last")
	`STMA_ASSERT_NXT(a_bk_merge_clears, clk, arst_n, (state_q == stma_pkg::BK_IDLE) && (state_d == stma_pkg::BK_WALK), (cnt_a_q == '0) && (cnt_b_q == '0) && !ovf_q, "counts not cleared at merge")

endmodule

[design/sparse_triplet_merge_add_core.sv]
// Top level of the sparse coordinate-list matrix add engine.
//
//  channel   handshake                        payload
//  --------  -------------------------------  ----------------------------------------
//  command   start / busy (start && !busy)    command, row, col, value
//  result    strobe (one cycle, no stall)     row_res, col_res, sum_value, entry_valid,
//                                             status, last
//  config    APB psel/penable/pwrite, pready  paddr, pwdata, prdata
//
//  Loads: one word per cycle sustained while no merge walk holds the queue;
//    each passes through the queue and is written to its list store by the back end.
//  Merge: the back end walks both stores one entry per cycle through the
//    registered RAM read port; a status-only merge gives one status word.
//  busy is high while the two-word command queue is full, i.e. while words
//    pile up behind a merge walk. Results cannot be stalled.
//  Reset (arst_n low) clears counts, overflow flag, queue and config (all
//    dimensions to 1); list stores are not cleared and need no clearing pass.
module sparse_triplet_merge_add_core #(
	parameter int MAX_TERMS  = 32,
	parameter int MAX_DIM    = 1024,
	parameter int VALUE_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// command word
	input  logic                             start,
	output logic                             busy,
	input  logic [stma_pkg::CMD_W-1:0]       command,
	input  logic [stma_pkg::ROW_W-1:0]       row,
	input  logic [stma_pkg::COL_W-1:0]       col,
	input  logic signed [VALUE_BITS-1:0]     value,
	// config
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [stma_pkg::PADDR_W-1:0]     paddr,
	input  logic [stma_pkg::PDATA_W-1:0]     pwdata,
	output logic [stma_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	// result word
	output logic                             strobe,
	output logic [stma_pkg::ROW_W-1:0]       row_res,
	output logic [stma_pkg::COL_W-1:0]       col_res,
	output logic signed [VALUE_BITS:0]       sum_value,
	output logic                             entry_valid,
	output logic [stma_pkg::STAT_W-1:0]      status,
	output logic                             last
);
	// queued word: control, row, col, value
	localparam int QW = $bits(stma_pkg::ctl_t) + stma_pkg::ROW_W + stma_pkg::COL_W +
		VALUE_BITS;

	logic          q_full, q_push, q_empty, q_pop;
	logic [QW-1:0] q_in_word, q_out_word;

	// front: config registers, dimension check, command classification
	stma_front #(
		.MAX_DIM    (MAX_DIM),
		.VALUE_BITS (VALUE_BITS),
		.QW         (QW)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.command (command),
		.row     (row),
		.col     (col),
		.value   (value),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_word  (q_in_word)
	);

	// decouples accept from execution so loads keep flowing one per cycle outside merge walks
	stma_queue #(
		.WIDTH (QW),
		.DEPTH (stma_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (q_in_word),
		.full      (q_full),
		.pop       (q_pop),
		.pop_word  (q_out_word),
		.empty     (q_empty)
	);

	// back: list stores, counts, merge walk, result register
	stma_back #(
		.MAX_TERMS  (MAX_TERMS),
		.VALUE_BITS (VALUE_BITS),
		.QW         (QW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_word      (q_out_word),
		.q_pop       (q_pop),
		.strobe      (strobe),
		.row_res     (row_res),
		.col_res     (col_res),
		.sum_value   (sum_value),
		.entry_valid (entry_valid),
		.status      (status),
		.last        (last)
	);

endmodule

[test/sparse_triplet_merge_add_core_tb.sv]
// Self-checking testbench for the sparse coordinate-list matrix add engine.
`timescale 1ns / 100ps

module testbench;

	localparam int MAX_TERMS   = 32;
	localparam int MAX_DIM     = 1024;
	localparam int VALUE_BITS  = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RAND_ITEMS  = 470;
	localparam int PHASE_ITEMS = 40;
	// latency pause before a register write: a trailing load word may still be in flight
	localparam int SETTLE      = 8;
	localparam int TAIL        = 20;

	// the fourth command code has no package name; the block ignores it
	localparam logic [stma_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

	// one command word as it goes onto the start/busy port
	typedef struct {
		logic [stma_pkg::CMD_W-1:0]   command;
		logic [stma_pkg::ROW_W-1:0]   row;
		logic [stma_pkg::COL_W-1:0]   col;
		logic signed [VALUE_BITS-1:0] value;
	} cmd_word_t;

	// one stored list entry, value already widened to the sum width
	typedef struct {
		logic [stma_pkg::ROW_W-1:0] row;
		logic [stma_pkg::COL_W-1:0] col;
		logic signed [VALUE_BITS:0] value;
	} term_t;

	// one result word as seen on the strobe port
	typedef struct {
		logic [stma_pkg::ROW_W-1:0]  row_res;
		logic [stma_pkg::COL_W-1:0]  col_res;
		logic signed [VALUE_BITS:0]  sum_value;
		logic                        entry_valid;
		logic [stma_pkg::STAT_W-1:0] status;
		logic                        last;
	} sum_word_t;

	// ---------------------------------------------------------------- DUT signals
	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           start = 1'b0;
	logic                           busy;
	logic [stma_pkg::CMD_W-1:0]     command = '0;
	logic [stma_pkg::ROW_W-1:0]     row = '0;
	logic [stma_pkg::COL_W-1:0]     col = '0;
	logic signed [VALUE_BITS-1:0]   value = '0;
	logic                           psel = 1'b0;
	logic                           penable = 1'b0;
	logic                           pwrite = 1'b0;
	logic [stma_pkg::PADDR_W-1:0]   paddr = '0;
	logic [stma_pkg::PDATA_W-1:0]   pwdata = '0;
	logic [stma_pkg::PDATA_W-1:0]   prdata;
	logic                           pready;
	logic                           strobe;
	logic [stma_pkg::ROW_W-1:0]     row_res;
	logic [stma_pkg::COL_W-1:0]     col_res;
	logic signed [VALUE_BITS:0]     sum_value;
	logic                           entry_valid;
	logic [stma_pkg::STAT_W-1:0]    status;
	logic                           last;

	sparse_triplet_merge_add_core #(
		.MAX_TERMS (MAX_TERMS),
		.MAX_DIM   (MAX_DIM),
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.row        (row),
		.col        (col),
		.value      (value),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.strobe     (strobe),
		.row_res    (row_res),
		.col_res    (col_res),
		.sum_value  (sum_value),
		.entry_valid(entry_valid),
		.status     (status),
		.last       (last)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------- shared state
	cmd_word_t pending_q[$];     // words waiting for the driver
	sum_word_t sum_words_q[$];   // predicted result words, oldest first
	cmd_word_t drv_word;         // word currently on the command port
	sum_word_t mon_exp;
	int        send_idle_pct = 32;
	int        n_errors = 0;
	int        cycle_count = 0;

	// predictor copy of the block's state
	logic [stma_pkg::CFG_W-1:0] dim_reg [4];
	term_t                      a_terms [MAX_TERMS];
	term_t                      b_terms [MAX_TERMS];
	int                         a_count;
	int                         b_count;
	bit                         list_overflow;

	// ---------------------------------------------------------------- predictor
	function automatic bit dim_out_of_range(logic [stma_pkg::CFG_W-1:0] d);
		return d == 0 || d > MAX_DIM;
	endfunction

	function automatic sum_word_t entry_word(logic [stma_pkg::ROW_W-1:0] r,
			logic [stma_pkg::COL_W-1:0] c, logic signed [VALUE_BITS:0] v);
		return '{row_res: r, col_res: c, sum_value: v, entry_valid: 1'b1,
			status: stma_pkg::ST_OK, last: 1'b0};
	endfunction

	// Applies one accepted word to the predicted state; a merge queues its result words.
	function automatic void predict_sum_words(cmd_word_t w);
		sum_word_t                   out_q[$];
		term_t                       ta;
		term_t                       tb;
		term_t                       t;
		logic [stma_pkg::STAT_W-1:0] st;
		int                          i;
		int                          j;
		t = '{row: w.row, col: w.col, value: {w.value[VALUE_BITS-1], w.value}};
		if (w.command == stma_pkg::CMD_LOAD_A) begin
			if (a_count >= MAX_TERMS) list_overflow = 1'b1;
			else begin
				a_terms[a_count] = t;
				a_count++;
			end
		end else if (w.command == stma_pkg::CMD_LOAD_B) begin
			if (b_count >= MAX_TERMS) list_overflow = 1'b1;
			else begin
				b_terms[b_count] = t;
				b_count++;
			end
		end else if (w.command == stma_pkg::CMD_MERGE) begin
			// dimension check wins over overflow, overflow over both-empty
			if (dim_reg[stma_pkg::REG_ROWS_A] != dim_reg[stma_pkg::REG_ROWS_B] ||
					dim_reg[stma_pkg::REG_COLS_A] != dim_reg[stma_pkg::REG_COLS_B] ||
					dim_out_of_range(dim_reg[stma_pkg::REG_ROWS_A]) ||
					dim_out_of_range(dim_reg[stma_pkg::REG_COLS_A]) ||
					dim_out_of_range(dim_reg[stma_pkg::REG_ROWS_B]) ||
					dim_out_of_range(dim_reg[stma_pkg::REG_COLS_B]))
				st = stma_pkg::ST_DIM;
			else if (list_overflow)
				st = stma_pkg::ST_OVF;
			else if (a_count == 0 && b_count == 0)
				st = stma_pkg::ST_EMPTY;
			else
				st = stma_pkg::ST_OK;

			if (st != stma_pkg::ST_OK) begin
				out_q.push_back('{row_res: '0, col_res: '0, sum_value: '0,
					entry_valid: 1'b0, status: st, last: 1'b0});
			end else begin
				i = 0;
				j = 0;
				// row-major compare-and-advance; no order check on either list
				while (i < a_count && j < b_count) begin
					ta = a_terms[i];
					tb = b_terms[j];
					if (ta.row < tb.row || (ta.row == tb.row && ta.col < tb.col)) begin
						out_q.push_back(entry_word(ta.row, ta.col, ta.value));
						i++;
					end else if (ta.row > tb.row || ta.col > tb.col) begin
						out_q.push_back(entry_word(tb.row, tb.col, tb.value));
						j++;
					end else begin
						// same coordinate: one word with the sum, kept even if zero
						out_q.push_back(entry_word(ta.row, ta.col, ta.value + tb.value));
						i++;
						j++;
					end
				end
				while (i < a_count) begin
					out_q.push_back(entry_word(a_terms[i].row, a_terms[i].col,
						a_terms[i].value));
					i++;
				end
				while (j < b_count) begin
					out_q.push_back(entry_word(b_terms[j].row, b_terms[j].col,
						b_terms[j].value));
					j++;
				end
			end
			out_q[out_q.size()-1].last = 1'b1;
			foreach (out_q[k]) sum_words_q.push_back(out_q[k]);
			a_count = 0;
			b_count = 0;
			list_overflow = 1'b0;
		end
		// CMD_UNUSED: nothing
	endfunction

	// ---------------------------------------------------------------- driver
	// A word is taken at an edge with start high and busy low. While busy holds
	// it off, the word and start stay put; otherwise a new word goes out or
	// start drops, decided by the current idle rate.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) predict_sum_words(drv_word);
			if (!(start && busy)) begin
				if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					drv_word = pending_q.pop_front();
					start   <= 1'b1;
					command <= drv_word.command;
					row     <= drv_word.row;
					col     <= drv_word.col;
					value   <= drv_word.value;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor
	// Results cannot be stalled: every strobe cycle is one word.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (sum_words_q.size() == 0) begin
				$error("result word with nothing expected: row_res %0d col_res %0d status %0d",
					row_res, col_res, status);
				n_errors++;
			end else begin
				mon_exp = sum_words_q.pop_front();
				if (row_res !== mon_exp.row_res) begin
					$error("row_res: expected %0d, got %0d", mon_exp.row_res, row_res);
					n_errors++;
				end
				if (col_res !== mon_exp.col_res) begin
					$error("col_res: expected %0d, got %0d", mon_exp.col_res, col_res);
					n_errors++;
				end
				if (sum_value !== mon_exp.sum_value) begin
					$error("sum_value: expected %0d, got %0d", mon_exp.sum_value, sum_value);
					n_errors++;
				end
				if (entry_valid !== mon_exp.entry_valid) begin
					$error("entry_valid: expected %0d, got %0d", mon_exp.entry_valid,
						entry_valid);
					n_errors++;
				end
				if (status !== mon_exp.status) begin
					$error("status: expected %0d, got %0d", mon_exp.status, status);
					n_errors++;
				end
				if (last !== mon_exp.last) begin
					$error("last: expected %0d, got %0d", mon_exp.last, last);
					n_errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus helpers
	// Coordinates arrive as plain integers and keep their low bits.
	function automatic void push_word(logic [stma_pkg::CMD_W-1:0] cmd, int unsigned r,
			int unsigned c, logic [VALUE_BITS-1:0] v);
		pending_q.push_back('{command: cmd, row: r[stma_pkg::ROW_W-1:0],
			col: c[stma_pkg::COL_W-1:0], value: v});
	endfunction

	function automatic logic [VALUE_BITS-1:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom();
		endcase
	endfunction

	// Queues one command sequence and returns how many words count as stimulus
	// (ignored words do not). Mostly well-formed: two sorted lists drawn from one
	// coordinate walk, so shared coordinates meet in the merge.
	function automatic int gen_sequence();
		cmd_word_t                  la[$];
		cmd_word_t                  lb[$];
		int                         kind;
		int                         n;
		int                         npos;
		int                         which;
		int                         r;
		int                         c;
		int                         cnt;
		logic [stma_pkg::CMD_W-1:0] tgt;
		cnt  = 0;
		kind = $urandom_range(0, 19);
		case (kind)
			0: begin
				// ignored command code
				n = $urandom_range(1, 3);
				repeat (n) push_word(CMD_UNUSED, $urandom(), $urandom(), $urandom());
				return 0;
			end
			1: begin
				// past capacity: extra loads dropped, merge reports overflow
				tgt = $urandom_range(0, 1) ? stma_pkg::CMD_LOAD_B : stma_pkg::CMD_LOAD_A;
				n   = $urandom_range(MAX_TERMS + 1, MAX_TERMS + 3);
				repeat (n) push_word(tgt, $urandom(), $urandom(), rand_value());
				push_word(stma_pkg::CMD_MERGE, $urandom(), $urandom(), $urandom());
				return n + 1;
			end
			3: begin
				// unsorted lists with scattered coordinates
				n = $urandom_range(1, 6);
				repeat (n) push_word($urandom_range(0, 1) ? stma_pkg::CMD_LOAD_B :
					stma_pkg::CMD_LOAD_A, $urandom(), $urandom(), rand_value());
				push_word(stma_pkg::CMD_MERGE, $urandom(), $urandom(), $urandom());
				return n + 1;
			end
			4: begin
				// loads left pending into the next sequence
				n = $urandom_range(1, 3);
				repeat (n) push_word($urandom_range(0, 1) ? stma_pkg::CMD_LOAD_B :
					stma_pkg::CMD_LOAD_A, $urandom(), $urandom(), rand_value());
				return n;
			end
			5: begin
				push_word(stma_pkg::CMD_MERGE, $urandom(), $urandom(), $urandom());
				return 1;
			end
			default: begin
				// kind 2 fills list A to capacity exactly
				npos = (kind == 2) ? MAX_TERMS : $urandom_range(1, 10);
				r    = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) :
					$urandom_range(0, 3);
				c    = $urandom_range(0, 15);
				for (int p = 0; p < npos; p++) begin
					// 0: A only, 1: B only, 2: both
					which = (kind == 2) ? 2 * $urandom_range(0, 1) : $urandom_range(0, 2);
					if (which != 1) la.push_back('{stma_pkg::CMD_LOAD_A, r[9:0], c[9:0],
						rand_value()});
					if (which != 0) lb.push_back('{stma_pkg::CMD_LOAD_B, r[9:0], c[9:0],
						rand_value()});
					if ($urandom_range(0, 3) == 0) begin
						r += $urandom_range(1, 200);
						c  = $urandom_range(0, 15);
					end else begin
						c += $urandom_range(1, 200);
						if (c > 1023) begin
							r++;
							c = $urandom_range(0, 7);
						end
					end
				end
				// interleave the two load streams, each keeping its own order
				while (la.size() != 0 || lb.size() != 0) begin
					if (lb.size() == 0 || (la.size() != 0 && $urandom_range(0, 1)))
						pending_q.push_back(la.pop_front());
					else
						pending_q.push_back(lb.pop_front());
					cnt++;
				end
				push_word(stma_pkg::CMD_MERGE, $urandom(), $urandom(), $urandom());
				return cnt + 1;
			end
		endcase
	endfunction

	// Waits until the driver has nothing left and every expected word has come,
	// then lets a trailing load settle.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_q.size() != 0 || start || sum_words_q.size() != 0) @(negedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready.
	task automatic apb_write(logic [1:0] idx, logic [stma_pkg::PDATA_W-1:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		dim_reg[idx] = data[stma_pkg::CFG_W-1:0];
	endtask

	task automatic program_dims(logic [stma_pkg::PDATA_W-1:0] ra,
			logic [stma_pkg::PDATA_W-1:0] ca, logic [stma_pkg::PDATA_W-1:0] rb,
			logic [stma_pkg::PDATA_W-1:0] cb);
		apb_write(stma_pkg::REG_ROWS_A, ra);
		apb_write(stma_pkg::REG_COLS_A, ca);
		apb_write(stma_pkg::REG_ROWS_B, rb);
		apb_write(stma_pkg::REG_COLS_B, cb);
	endtask

	// Picks a dimension setting: mostly legal and matching, with the extremes,
	// mismatches, out-of-range values and junk in the unused upper bits.
	task automatic random_dims();
		logic [stma_pkg::PDATA_W-1:0] dr;
		logic [stma_pkg::PDATA_W-1:0] dc;
		logic [stma_pkg::PDATA_W-1:0] bad;
		dr = $urandom_range(1, MAX_DIM);
		dc = $urandom_range(1, MAX_DIM);
		case ($urandom_range(0, 11))
			0: program_dims(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM);
			1: program_dims(1, 1, 1, 1);
			2: program_dims({21'($urandom_range(0, 2097151)), dr[10:0]},
				{21'($urandom_range(0, 2097151)), dc[10:0]},
				{21'($urandom_range(0, 2097151)), dr[10:0]},
				{21'($urandom_range(0, 2097151)), dc[10:0]});
			3: program_dims(dr, dc, (dr == MAX_DIM) ? 1 : dr + 1, dc);
			4: program_dims(dr, dc, dr, (dc == 1) ? MAX_DIM : dc - 1);
			5: begin
				// equal but out of range
				case ($urandom_range(0, 3))
					0: bad = 0;
					1: bad = MAX_DIM + 1;
					2: bad = 2047;
					default: bad = $urandom_range(MAX_DIM + 1, 2047);
				endcase
				if ($urandom_range(0, 1)) program_dims(bad, dc, bad, dc);
				else program_dims(dr, bad, dr, bad);
			end
			default: program_dims(dr, dc, dr, dc);
		endcase
	endtask

	// ---------------------------------------------------------------- test sequence
	initial begin
		int rand_items;
		int phase_items;
		rand_items = 0;
		// predictor reset state
		foreach (dim_reg[k]) dim_reg[k] = 11'd1;
		a_count       = 0;
		b_count       = 0;
		list_overflow = 1'b0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset dimensions (1 x 1); empty merge, then a single entry
		push_word(stma_pkg::CMD_MERGE, 0, 0, 0);
		push_word(stma_pkg::CMD_LOAD_A, 0, 0, 32'd5);
		push_word(stma_pkg::CMD_MERGE, 0, 0, 0);
		wait_idle();

		// directed: largest legal dimensions
		program_dims(MAX_DIM, MAX_DIM, MAX_DIM, MAX_DIM);
		@(negedge clk);
		// value extremes meet at both coordinate extremes: sums need the extra bit
		push_word(stma_pkg::CMD_LOAD_A, 0, 0, 32'h7FFF_FFFF);
		push_word(stma_pkg::CMD_LOAD_B, 0, 0, 32'h7FFF_FFFF);
		push_word(stma_pkg::CMD_LOAD_A, 1023, 1023, 32'h8000_0000);
		push_word(stma_pkg::CMD_LOAD_B, 1023, 1023, 32'h8000_0000);
		push_word(stma_pkg::CMD_MERGE, 1023, 1023, 32'hFFFF_FFFF);
		// zero sum kept, ignored command in the middle, B leads, A leftover
		push_word(stma_pkg::CMD_LOAD_B, 0, 5, -32'sd1);
		push_word(stma_pkg::CMD_LOAD_A, 2, 3, 32'd7);
		push_word(CMD_UNUSED, 1023, 1023, 32'hFFFF_FFFF);
		push_word(stma_pkg::CMD_LOAD_B, 2, 3, -32'sd7);
		push_word(stma_pkg::CMD_LOAD_A, 4, 0, 32'd1);
		push_word(stma_pkg::CMD_MERGE, 0, 0, 0);
		// unsorted list A
		push_word(stma_pkg::CMD_LOAD_A, 9, 9, 32'd1);
		push_word(stma_pkg::CMD_LOAD_A, 0, 0, 32'd2);
		push_word(stma_pkg::CMD_LOAD_B, 4, 4, 32'd3);
		push_word(stma_pkg::CMD_MERGE, 0, 0, 0);
		// B only
		push_word(stma_pkg::CMD_LOAD_B, 7, 1, 32'h1234_5678);
		push_word(stma_pkg::CMD_MERGE, 0, 0, 0);
		wait_idle();

		// directed: zero rows in A: dimension status, counts still cleared
		apb_write(stma_pkg::REG_ROWS_A, 0);
		@(negedge clk);
		push_word(stma_pkg::CMD_LOAD_A, 1, 1, 32'd1);
		push_word(stma_pkg::CMD_MERGE, 0, 0, 0);
		push_word(stma_pkg::CMD_MERGE, 0, 0, 0);
		wait_idle();

		// random phases; each starts from an idle block with a fresh setting,
		// and the sender waits for every result before the next one
		while (rand_items < RAND_ITEMS) begin
			random_dims();
			@(negedge clk);
			if (rand_items < RAND_ITEMS / 3)
				send_idle_pct = 32;
			else if (rand_items < 2 * RAND_ITEMS / 3)
				send_idle_pct = 48;
			else
				send_idle_pct = 0;
			phase_items = 0;
			while (phase_items < PHASE_ITEMS) phase_items += gen_sequence();
			rand_items += phase_items;
			wait_idle();
		end

		repeat (TAIL) @(posedge clk);
		if (n_errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
